>>> design/dle_byte_stuffing_deframer_defines.svh
// Assertion macros shared by the deframer's checker.
`ifndef DLE_BYTE_STUFFING_DEFRAMER_DEFINES_SVH
`define DLE_BYTE_STUFFING_DEFRAMER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define DLE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define DLE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/dle_pkg.sv
// Types and constants of the DLE/STX/ETX deframer.
package dle_pkg;

	localparam logic [7:0] STX_BYTE = 8'h02;
	localparam logic [7:0] ETX_BYTE = 8'h03;
	localparam logic [7:0] DLE_BYTE = 8'h10;

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// What the back end must emit for one queued entry.
	typedef enum logic [1:0] {
		CMD_ONE,
		CMD_PAIR,
		CMD_END
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] byte_val;
		logic       bad;
	} cmd_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       data_valid;
		logic       frame_end;
		logic       frame_bad;
		logic       item_last;
	} out_word_t;

endpackage

>>> design/dle_in_if.sv
// Input channel: raw framed bytes.
interface dle_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       frame_last;

	modport source (output valid, output in_byte, output frame_last, input ready);
	modport sink   (input valid, input in_byte, input frame_last, output ready);
endinterface

>>> design/dle_out_if.sv
// Output channel: unescaped payload bytes and frame verdicts.
interface dle_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       data_valid;
	logic       frame_end;
	logic       frame_bad;
	logic       item_last;

	modport source (output valid, output data_byte, output data_valid, output frame_end,
		output frame_bad, output item_last, input ready);
	modport sink   (input valid, input data_byte, input data_valid, input frame_end,
		input frame_bad, input item_last, output ready);
endinterface

>>> design/dle_front.sv
// Front end: accepts raw bytes, tracks framing state, queues emit commands.
module dle_front (
	input  logic          clk,
	input  logic          arst_n,
	dle_in_if.sink        framed,
	input  logic          q_full,
	output logic          push,
	output dle_pkg::cmd_t push_cmd
);

	logic at_start_q;
	logic esc_q;
	logic start_bad_q;
	logic acc;

	assign framed.ready = !q_full;
	assign acc = framed.valid && framed.ready;

	always_comb begin
		push              = 1'b0;
		push_cmd.kind     = dle_pkg::CMD_ONE;
		push_cmd.byte_val = framed.in_byte;
		push_cmd.bad      = 1'b0;
		if (acc) begin
			if (framed.frame_last) begin
				push          = 1'b1;
				push_cmd.kind = dle_pkg::CMD_END;
				push_cmd.bad  = at_start_q || start_bad_q ||
					(framed.in_byte != dle_pkg::ETX_BYTE);
			end else if (at_start_q) begin
				push = 1'b0;
			end else if (esc_q) begin
				push = 1'b1;
				if (framed.in_byte inside {dle_pkg::STX_BYTE, dle_pkg::ETX_BYTE,
					dle_pkg::DLE_BYTE}) begin
					push_cmd.kind = dle_pkg::CMD_ONE;
				end else begin
					push_cmd.kind = dle_pkg::CMD_PAIR;
				end
			end else if (framed.in_byte != dle_pkg::DLE_BYTE) begin
				push = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q  <= 1'b1;
			esc_q       <= 1'b0;
			start_bad_q <= 1'b0;
		end else if (acc) begin
			if (framed.frame_last) begin
				at_start_q  <= 1'b1;
				esc_q       <= 1'b0;
				start_bad_q <= 1'b0;
			end else if (at_start_q) begin
				at_start_q  <= 1'b0;
				esc_q       <= 1'b0;
				start_bad_q <= (framed.in_byte != dle_pkg::STX_BYTE);
			end else if (esc_q) begin
				esc_q <= 1'b0;
			end else begin
				esc_q <= (framed.in_byte == dle_pkg::DLE_BYTE);
			end
		end
	end

endmodule

>>> design/dle_queue.sv
// Small command queue between front and back end.
module dle_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  dle_pkg::cmd_t push_cmd,
	input  logic          pop,
	output dle_pkg::cmd_t head,
	output logic          empty,
	output logic          full
);

	dle_pkg::cmd_t                 mem_q [dle_pkg::Q_DEPTH];
	logic [dle_pkg::Q_PTR_W-1:0]   wr_ptr_q;
	logic [dle_pkg::Q_PTR_W-1:0]   rd_ptr_q;
	logic [dle_pkg::Q_CNT_W-1:0]   count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == dle_pkg::Q_CNT_W'(dle_pkg::Q_DEPTH));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> design/dle_back.sv
// Back end: expands queued commands into output words behind an output register.
module dle_back (
	input  logic          clk,
	input  logic          arst_n,
	input  dle_pkg::cmd_t head,
	input  logic          empty,
	output logic          pop,
	dle_out_if.source     deframed
);

	logic               valid_q;
	logic               phase_q;
	dle_pkg::out_word_t word_q;
	dle_pkg::out_word_t word_nxt;
	logic               ld;
	logic               first_of_pair;

	assign ld            = !valid_q || deframed.ready;
	assign first_of_pair = (head.kind == dle_pkg::CMD_PAIR) && !phase_q;
	assign pop           = ld && !empty && !first_of_pair;

	always_comb begin
		word_nxt.data_byte  = head.byte_val;
		word_nxt.data_valid = 1'b1;
		word_nxt.frame_end  = 1'b0;
		word_nxt.frame_bad  = 1'b0;
		word_nxt.item_last  = 1'b1;
		case (head.kind)
			dle_pkg::CMD_ONE: begin
				word_nxt.item_last = 1'b1;
			end
			dle_pkg::CMD_PAIR: begin
				// escaped ordinary byte: DLE goes out first
				if (!phase_q) begin
					word_nxt.data_byte = dle_pkg::DLE_BYTE;
					word_nxt.item_last = 1'b0;
				end
			end
			dle_pkg::CMD_END: begin
				word_nxt.data_byte  = 8'h00;
				word_nxt.data_valid = 1'b0;
				word_nxt.frame_end  = 1'b1;
				word_nxt.frame_bad  = head.bad;
			end
			default: begin
				word_nxt.data_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (ld) begin
			valid_q <= !empty;
			if (!empty) begin
				phase_q <= first_of_pair;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld && !empty) begin
			word_q <= word_nxt;
		end
	end

	assign deframed.valid      = valid_q;
	assign deframed.data_byte  = word_q.data_byte;
	assign deframed.data_valid = word_q.data_valid;
	assign deframed.frame_end  = word_q.frame_end;
	assign deframed.frame_bad  = word_q.frame_bad;
	assign deframed.item_last  = word_q.item_last;

endmodule

>>> design/dle_byte_stuffing_deframer.sv
// DLE/STX/ETX deframer: takes one raw byte per word on framed, marks the frame's
// last byte with frame_last, and returns unescaped payload bytes on deframed with
// a closing word that carries frame_end and the frame_bad verdict. Bad frames are
// not dropped here; downstream logic discards them. The input takes one byte per
// cycle while the two-entry command queue has room; the output register sends one
// word per cycle while the receiver is ready, so a DLE followed by an ordinary
// byte is sent as two output words and, with the output never stalled, is the
// only case that can hold the input off. A stalled receiver holds the input off
// once the queue fills. A byte's first result passes through the command queue
// and the output register before it is offered on deframed.
module dle_byte_stuffing_deframer (
	input  logic      clk,
	input  logic      arst_n,
	dle_in_if.sink    framed,
	dle_out_if.source deframed
);

	logic          push;
	dle_pkg::cmd_t push_cmd;
	logic          pop;
	dle_pkg::cmd_t head;
	logic          empty;
	logic          full;

	dle_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.framed   (framed),
		.q_full   (full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	dle_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	dle_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.deframed (deframed)
	);

endmodule

>>> design/dle_checker.sv
// Port-level checker for the deframer, bound to the top level.
`include "dle_byte_stuffing_deframer_defines.svh"

module dle_checker (
	input logic       clk,
	input logic       arst_n,
	dle_out_if.source deframed
);

	`DLE_ASSERT_NEXT(a_out_hold, deframed.valid && !deframed.ready, deframed.valid && $stable(deframed.data_byte) && $stable(deframed.item_last) && $stable(deframed.frame_end), "output word changed while stalled")
	`DLE_ASSERT_NOW(a_end_empty, deframed.valid && deframed.frame_end, !deframed.data_valid && (deframed.data_byte == 8'h00) && deframed.item_last, "frame end word carries payload")
	`DLE_ASSERT_NOW(a_data_clean, deframed.valid && !deframed.frame_end, deframed.data_valid && !deframed.frame_bad, "payload word has bad flag or no data")
	`DLE_ASSERT_NOW(a_pair_head, deframed.valid && !deframed.item_last, (deframed.data_byte == dle_pkg::DLE_BYTE) && !deframed.frame_end, "split word is not a DLE")

endmodule

bind dle_byte_stuffing_deframer dle_checker u_dle_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.deframed (deframed)
);
